[rtl/core/skt_pkg.sv]
// shared types and codes for the sorted key table
`timescale 1ns / 1ps
package skt_pkg;

	// default table depth
	localparam int CAPACITY_DEF = 16;

	// field widths
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // capture word and compare vectors
		logic update;  // apply shift and count change
	} skt_ctl_t;

endpackage

[rtl/core/skt_ctrl.sv]
// controller state machine for the sorted key table
`timescale 1ns / 1ps
module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output skt_pkg::skt_ctl_t ctl,
	output logic              busy,
	output logic              done
);
	import skt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_UPD;
			end
			S_UPD: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and result strobe registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_UPD);
		end
	end

	// command outputs
	assign ctl.load   = (state_q == S_IDLE) && start;
	assign ctl.update = (state_q == S_UPD);
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;

endmodule

[rtl/core/skt_dpath.sv]
// key row, parallel compare and shift datapath for the sorted key table
`timescale 1ns / 1ps
module skt_dpath #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skt_pkg::skt_ctl_t             ctl,
	input  logic [skt_pkg::CMD_W-1:0]     cmd,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	output logic [skt_pkg::STATUS_W-1:0]  status,
	output logic [skt_pkg::COUNT_W-1:0]   count
);
	import skt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]    store_q [CAPACITY];
	logic [KEY_W-1:0]    store_nxt [CAPACITY];
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic [CAPACITY-1:0] lt_cmb;
	logic [CAPACITY-1:0] eq_cmb;
	logic [CAPACITY-1:0] lt_s1;
	logic [CAPACITY-1:0] eq_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_nxt;
	logic                full;
	logic                found;
	logic                do_ins;
	logic                do_rem;
	logic [CW+COUNT_W-1:0] count_ext;

	// per-entry compare against the incoming word, only live entries count
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_cmb[i] = (CW'(i) < count_q) && ($signed(store_q[i]) < key);
			eq_cmb[i] = (CW'(i) < count_q) && (store_q[i] == key);
		end
	end

	// capture the word and its compare vectors
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_s1 <= cmd;
			key_s1 <= key;
			lt_s1  <= lt_cmb;
			eq_s1  <= eq_cmb;
		end
	end

	assign full   = (count_q == CW'(CAPACITY));
	assign found  = |eq_s1;
	assign do_ins = (cmd_s1 == CMD_INSERT) && !full;
	assign do_rem = (cmd_s1 == CMD_REMOVE) && found;

	// status and count for the result
	always_comb begin
		status_nxt = ST_NOT_FOUND;
		count_nxt  = count_q;
		case (cmd_s1)
			CMD_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_DONE;
					count_nxt  = count_q + 1'b1;
				end
			end
			CMD_SEARCH: begin
				if (found) status_nxt = ST_DONE;
			end
			CMD_REMOVE: begin
				if (found) begin
					status_nxt = ST_DONE;
					count_nxt  = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_NOT_FOUND;
			end
		endcase
	end

	// each entry keeps, takes the key, or takes a neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			store_nxt[i] = store_q[i];
			if (do_ins && !lt_s1[i]) begin
				if (i == 0) begin
					store_nxt[i] = key_s1;
				end else if (lt_s1[(i == 0) ? 0 : i - 1]) begin
					store_nxt[i] = key_s1;
				end else begin
					store_nxt[i] = store_q[(i == 0) ? 0 : i - 1];
				end
			end else if (do_rem && !lt_s1[i] && (i < CAPACITY - 1)) begin
				store_nxt[i] = store_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	// key row and status update
	always_ff @(posedge clk) begin
		if (ctl.update) begin
			for (int i = 0; i < CAPACITY; i++) begin
				store_q[i] <= store_nxt[i];
			end
			status_q <= status_nxt;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.update) begin
			count_q <= count_nxt;
		end
	end

	// count field carries the low bits
	assign count_ext = {{COUNT_W{1'b0}}, count_q};
	assign count     = count_ext[COUNT_W-1:0];
	assign status    = status_q;

endmodule

[rtl/core/sorted_key_table.sv]
// top level of the sorted key table
`timescale 1ns / 1ps
// Sorted table of signed 32-bit keys, ascending, duplicates allowed.
// Command channel: drive cmd and key with start high; the word is taken at a
// clock edge where start is high and busy is low. cmd 0 inserts, 1 searches,
// 2 removes one copy of the key.
// Result channel: done is high for one cycle with status and count; the
// receiver must take it then, there is no backpressure.
// status 0 done or found, 1 not found, 2 table full on insert (key dropped).
// count is the number of keys held after the operation, low five bits.
// Timing: the parallel compare is registered as a word is taken, the next
// cycle applies the shift across the key row, and the result shows the cycle
// after that. busy is high for one cycle and no word is taken meanwhile; the
// result of one word is shown in the first cycle its successor can be taken.
// The busy cycle stems from the registered compare vector feeding the shift.
// Reset clears the entry count and the controller; key contents are not
// cleared, entries at or above the count are never consulted.
module sorted_key_table #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [skt_pkg::CMD_W-1:0]        cmd,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	output logic                             done,
	output logic [skt_pkg::STATUS_W-1:0]     status,
	output logic [skt_pkg::COUNT_W-1:0]      count
);
	import skt_pkg::*;

	skt_ctl_t ctl;

	// sequencer
	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// key row and compare logic
	skt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.key    (key),
		.status (status),
		.count  (count)
	);

`ifndef ASSERT_OFF
	localparam logic [COUNT_W-1:0] CAP_LOW = COUNT_W'(CAPACITY);

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding work cycle");

	// a taken word makes the block busy next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("taken word did not start work");

	// a full report carries a full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == CAP_LOW))
		else $error("full status with a count below capacity");
`endif

endmodule

[test/tb_sorted_key_table.sv]
// self-checking testbench for the sorted key table
`timescale 1ns / 1ps
module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	// command code with no operation behind it
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} table_reply_t;

	// mirror of the key table and the replies still owed by the block
	class key_table_tracker;
		logic signed [KEY_W-1:0] held[$];
		table_reply_t            owed[$];
		int                      errors;

		function new();
			errors = 0;
		endfunction

		// apply one accepted word to the mirror and queue its reply
		function void note_word(logic [CMD_W-1:0] op, logic signed [KEY_W-1:0] k);
			table_reply_t r;
			int pos;
			pos = 0;
			r.status = ST_NOT_FOUND;
			while (pos < held.size() && held[pos] < k)
				pos++;
			if (op == CMD_INSERT) begin
				if (held.size() >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					held.insert(pos, k);
					r.status = ST_DONE;
				end
			end else if (op == CMD_SEARCH || op == CMD_REMOVE) begin
				if (pos < held.size() && held[pos] == k) begin
					r.status = ST_DONE;
					if (op == CMD_REMOVE)
						held.delete(pos);
				end
			end
			r.count = COUNT_W'(held.size());
			owed.push_back(r);
		endfunction

		// compare one reply with the oldest one owed
		function void check_reply(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
			table_reply_t r;
			if (owed.size() == 0) begin
				$error("reply with none owed: status %0d count %0d", st, cnt);
				errors++;
				return;
			end
			r = owed.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (cnt !== r.count) begin
				$error("count: expected %0d, got %0d", r.count, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function logic signed [KEY_W-1:0] any_held();
			if (held.size() == 0)
				return $urandom;
			return held[$urandom_range(held.size() - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [CMD_W-1:0] cmd;
	logic signed [KEY_W-1:0] key;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] count;

	key_table_tracker tracker;
	int quiet_cycles;
	bit filling;

	sorted_key_table #(.CAPACITY(CAPACITY)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.key(key),
		.done(done),
		.status(status),
		.count(count)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// reply check, word capture and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_reply(status, count);
			if (start && !busy)
				tracker.note_word(cmd, key);
			if (done || (start && !busy)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// present one word and hold it until taken
	task automatic send_word(logic [CMD_W-1:0] op, logic signed [KEY_W-1:0] k);
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		key <= k;
		do
			@(posedge clk);
		while (busy);
	endtask

	// random sender gaps, idle_pct out of a hundred per cycle
	task automatic sender_gap(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// hold off until every owed reply has come back
	task automatic drain_replies();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] some_key();
		int roll;
		int pick;
		roll = $urandom_range(99);
		if (roll < 20) begin
			pick = $urandom_range(4);
			case (pick)
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return -1;
				3: return 0;
				default: return 1;
			endcase
		end else if (roll < 55) begin
			pick = $urandom_range(14);
			return pick - 7;
		end
		return $urandom;
	endfunction

	// fill toward full, then drain toward empty, with random content
	task automatic random_word(output logic [CMD_W-1:0] op, output logic signed [KEY_W-1:0] k);
		int roll;
		roll = $urandom_range(99);
		if (tracker.held.size() >= CAPACITY && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (tracker.held.size() == 0)
			filling = 1'b1;
		if (roll < 5)
			op = CMD_SPARE;
		else if (roll < (filling ? 70 : 25))
			op = CMD_INSERT;
		else if (roll < (filling ? 88 : 45))
			op = CMD_SEARCH;
		else
			op = CMD_REMOVE;
		if (op == CMD_INSERT)
			k = ($urandom_range(99) < 25) ? tracker.any_held() : some_key();
		else
			k = ($urandom_range(99) < 65) ? tracker.any_held() : some_key();
	endtask

	initial begin
		logic [CMD_W-1:0] op;
		logic signed [KEY_W-1:0] k;
		int idle_pct;
		tracker = new();
		filling = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_INSERT;
		key = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table cases
		send_word(CMD_SEARCH, 0);
		send_word(CMD_REMOVE, 0);
		send_word(CMD_SPARE, 0);
		// extremes, duplicates, found and absent keys
		send_word(CMD_INSERT, KEY_MAX);
		send_word(CMD_INSERT, KEY_MIN);
		send_word(CMD_INSERT, 0);
		send_word(CMD_INSERT, -1);
		send_word(CMD_INSERT, 0);
		send_word(CMD_SEARCH, KEY_MIN);
		send_word(CMD_SEARCH, 5);
		send_word(CMD_REMOVE, 0);
		send_word(CMD_SEARCH, 0);
		send_word(CMD_REMOVE, 7);
		send_word(CMD_SPARE, KEY_MAX);
		send_word(CMD_REMOVE, KEY_MAX);
		// fill to capacity, then one insert too many
		while (tracker.held.size() < CAPACITY)
			send_word(CMD_INSERT, $urandom_range(20) - 10);
		send_word(CMD_INSERT, 3);
		send_word(CMD_SEARCH, KEY_MAX);
		drain_replies();

		// random traffic under three sender idling profiles
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 7 : ((phase == 1) ? 86 : 0);
			for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
				sender_gap(idle_pct);
				random_word(op, k);
				send_word(op, k);
			end
			drain_replies();
		end

		// let the last reply settle, then report
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d replies never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
